### design/pfva_pkg.sv
// pfva_pkg: shared types, constants and saturating helpers for the pair force
// and virial accumulator; used by pfva_ctrl, pfva_dp and the top level
// no dependencies
package pfva_pkg;

  // atom store depth and address width
  localparam int AtomCount = 4096;
  localparam int AtomAw    = $clog2(AtomCount);

  // fixed field widths
  localparam int IdxW   = 12;
  localparam int RacW   = 13;
  localparam int PosW   = 32;
  localparam int ForceW = 48;
  localparam int EnW    = 32;
  localparam int VirW   = 64;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_LOAD  = 3'd1,
    OP_BEGIN = 3'd2,
    OP_PAIR  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_NOMAP = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLR,
    S_PRDC,
    S_PDIFF,
    S_PMUL,
    S_DONE
  } ctrl_state_e;

  // which address the position and force memories read
  typedef enum logic [1:0] {
    RD_ITEM,
    RD_CENTER,
    RD_TARGET
  } rd_sel_e;

  typedef struct packed {
    logic              latch;
    logic              clr_sums;
    logic              sweep_we;
    logic [AtomAw-1:0] sweep_addr;
    logic              rd_en;
    rd_sel_e           rd_sel;
    logic              load_we;
    logic              begin_we;
    logic              center_we;
    logic              diff_en;
    logic              neigh_we;
    logic              mul_en;
    logic [2:0]        mul_sel;
    logic              acc_en;
    logic [2:0]        acc_sel;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic out_busy;
  } stat_t;

  // clamp a 49-bit sum to the signed 48-bit range
  function automatic logic signed [ForceW-1:0] sat48(input logic signed [ForceW:0] s);
    logic signed [ForceW-1:0] r;
    r = s[ForceW-1:0];
    if (s[ForceW] != s[ForceW-1]) begin
      r = s[ForceW] ? {1'b1, {(ForceW-1){1'b0}}} : {1'b0, {(ForceW-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp a 65-bit sum to the signed 64-bit range
  function automatic logic signed [VirW-1:0] sat64(input logic signed [VirW:0] s);
    logic signed [VirW-1:0] r;
    r = s[VirW-1:0];
    if (s[VirW] != s[VirW-1]) begin
      r = s[VirW] ? {1'b1, {(VirW-1){1'b0}}} : {1'b0, {(VirW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### design/pfva_ctrl.sv
// pfva_ctrl: sequencer for the accumulator, one operation at a time
// depends on pfva_pkg; drives pfva_dp through cmd_t, reads stat_t
module pfva_ctrl
  import pfva_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [AtomAw-1:0] sweep_q, sweep_d;
  logic [2:0]        mul_cnt_q, mul_cnt_d;
  logic              sweep_last;

  assign sweep_last = (sweep_q == AtomAw'(AtomCount - 1));
  assign s_ready_o  = (state_q == S_IDLE) && !stat_i.out_busy;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      sweep_q   <= '0;
      mul_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      mul_cnt_q <= mul_cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    mul_cnt_d  = mul_cnt_q;
    cmd_o      = '0;
    cmd_o.rd_sel     = RD_ITEM;
    cmd_o.sweep_addr = sweep_q;
    cmd_o.mul_sel    = mul_cnt_q;
    cmd_o.acc_sel    = mul_cnt_q - 3'd1;
    unique case (state_q)
      S_INIT, S_CLR: begin
        cmd_o.sweep_we = 1'b1;
        sweep_d = sweep_last ? '0 : sweep_q + AtomAw'(1);
        if (sweep_last) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (s_valid_i && s_ready_o) begin
          cmd_o.latch = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.op)
          OP_CLEAR: begin
            cmd_o.clr_sums = 1'b1;
            state_d = S_CLR;
          end
          OP_LOAD: begin
            cmd_o.load_we = 1'b1;
            state_d = S_DONE;
          end
          OP_BEGIN: begin
            cmd_o.begin_we = 1'b1;
            state_d = S_DONE;
          end
          OP_PAIR: begin
            // neighbor position and center force
            cmd_o.rd_en = 1'b1;
            state_d = S_PRDC;
          end
          OP_READ: begin
            cmd_o.rd_en = 1'b1;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PRDC: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RD_CENTER;
        cmd_o.center_we = 1'b1;
        state_d = S_PDIFF;
      end
      S_PDIFF: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RD_TARGET;
        cmd_o.diff_en = 1'b1;
        mul_cnt_d = '0;
        state_d = S_PMUL;
      end
      S_PMUL: begin
        // one product per cycle, accumulated the cycle after
        cmd_o.neigh_we = (mul_cnt_q == 3'd0);
        cmd_o.mul_en = (mul_cnt_q != 3'd6);
        cmd_o.acc_en = (mul_cnt_q != 3'd0);
        mul_cnt_d = mul_cnt_q + 3'd1;
        if (mul_cnt_q == 3'd6) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_IDLE)
    else $error("finish not followed by idle");
  a_force_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sweep_we, cmd_o.center_we, cmd_o.neigh_we}))
    else $error("force memory write conflict");
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !stat_i.out_busy)
    else $error("result register still occupied");
`endif

endmodule

### design/pfva_dp.sv
// pfva_dp: atom memories, force and virial arithmetic and result register
// depends on pfva_pkg; controlled by pfva_ctrl
module pfva_dp
  import pfva_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic [255:0]             in_data_i,
  input  logic [RacW-1:0]          rac_i,
  input  logic                     map_en_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [615:0]             out_data_o
);

  // latched item
  op_e                    op_q;
  logic [IdxW-1:0]        idx_q;
  logic signed [PosW-1:0] px_q, py_q, pz_q;
  logic [IdxW-1:0]        org_in_q;
  logic signed [31:0]     fx_q, fy_q, fz_q;
  logic signed [EnW-1:0]  en_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= op_e'(in_data_i[2:0]);
      idx_q    <= in_data_i[14:3];
      px_q     <= in_data_i[46:15];
      py_q     <= in_data_i[78:47];
      pz_q     <= in_data_i[110:79];
      org_in_q <= in_data_i[122:111];
      fx_q     <= in_data_i[154:123];
      fy_q     <= in_data_i[186:155];
      fz_q     <= in_data_i[218:187];
      en_q     <= in_data_i[250:219];
    end
  end

  // global state
  logic [AtomAw-1:0]        center_q;
  logic signed [ForceW-1:0] etot_q;
  logic signed [VirW-1:0]   vir_q [6];
  logic [AtomAw-1:0]        tgt_q;
  logic                     upd_q;
  status_e                  stat_q;
  logic                     valid_q;

  logic [AtomAw-1:0] idx_a;
  assign idx_a = AtomAw'(idx_q);

  // memories
  logic signed [PosW-1:0]   mpx [AtomCount];
  logic signed [PosW-1:0]   mpy [AtomCount];
  logic signed [PosW-1:0]   mpz [AtomCount];
  logic [IdxW-1:0]          morg [AtomCount];
  logic signed [ForceW-1:0] mfx [AtomCount];
  logic signed [ForceW-1:0] mfy [AtomCount];
  logic signed [ForceW-1:0] mfz [AtomCount];
  logic signed [EnW-1:0]    men [AtomCount];

  logic signed [PosW-1:0]   rpx_q, rpy_q, rpz_q;
  logic [IdxW-1:0]          rorg_q;
  logic signed [ForceW-1:0] rfx_q, rfy_q, rfz_q;
  logic signed [EnW-1:0]    ren_q;

  logic [AtomAw-1:0] pos_raddr, f_raddr, f_waddr;
  logic              f_we, f_sub;
  logic signed [ForceW-1:0] wfx, wfy, wfz;
  logic [AtomAw-1:0] tgt_d;

  // read addresses
  always_comb begin
    pos_raddr = idx_a;
    f_raddr   = center_q;
    unique case (cmd_i.rd_sel)
      RD_ITEM:   begin pos_raddr = idx_a;    f_raddr = (op_q == OP_READ) ? idx_a : center_q; end
      RD_CENTER: begin pos_raddr = center_q; f_raddr = center_q; end
      RD_TARGET: begin pos_raddr = center_q; f_raddr = tgt_d; end
      default:   begin pos_raddr = idx_a;    f_raddr = center_q; end
    endcase
  end

  // force write: sweep zero, center add, neighbor subtract
  assign f_sub   = cmd_i.neigh_we;
  assign f_we    = cmd_i.sweep_we || cmd_i.center_we || (cmd_i.neigh_we && upd_q);
  assign f_waddr = cmd_i.sweep_we ? cmd_i.sweep_addr : (f_sub ? tgt_q : center_q);

  always_comb begin
    logic signed [ForceW:0] ax, ay, az;
    ax = f_sub ? -{{(ForceW-31){fx_q[31]}}, fx_q} : {{(ForceW-31){fx_q[31]}}, fx_q};
    ay = f_sub ? -{{(ForceW-31){fy_q[31]}}, fy_q} : {{(ForceW-31){fy_q[31]}}, fy_q};
    az = f_sub ? -{{(ForceW-31){fz_q[31]}}, fz_q} : {{(ForceW-31){fz_q[31]}}, fz_q};
    if (cmd_i.sweep_we) begin
      wfx = '0;
      wfy = '0;
      wfz = '0;
    end else begin
      wfx = sat48({rfx_q[ForceW-1], rfx_q} + ax);
      wfy = sat48({rfy_q[ForceW-1], rfy_q} + ay);
      wfz = sat48({rfz_q[ForceW-1], rfz_q} + az);
    end
  end

  // position and origin memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mpx[idx_a]  <= px_q;
      mpy[idx_a]  <= py_q;
      mpz[idx_a]  <= pz_q;
      morg[idx_a] <= org_in_q;
    end
    if (cmd_i.rd_en) begin
      rpx_q  <= mpx[pos_raddr];
      rpy_q  <= mpy[pos_raddr];
      rpz_q  <= mpz[pos_raddr];
      rorg_q <= morg[pos_raddr];
    end
  end

  // force memories
  always_ff @(posedge clk_i) begin
    if (f_we) begin
      mfx[f_waddr] <= wfx;
      mfy[f_waddr] <= wfy;
      mfz[f_waddr] <= wfz;
    end
    if (cmd_i.rd_en) begin
      rfx_q <= mfx[f_raddr];
      rfy_q <= mfy[f_raddr];
      rfz_q <= mfz[f_raddr];
    end
  end

  // energy memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_we) begin
      men[cmd_i.sweep_addr] <= '0;
    end else if (cmd_i.begin_we) begin
      men[idx_a] <= en_q;
    end
    if (cmd_i.rd_en) begin
      ren_q <= men[idx_a];
    end
  end

  // neighbor position held while center position is read
  logic signed [PosW-1:0] npx_q, npy_q, npz_q;
  logic [IdxW-1:0]        norg_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.center_we) begin
      npx_q  <= rpx_q;
      npy_q  <= rpy_q;
      npz_q  <= rpz_q;
      norg_q <= rorg_q;
    end
  end

  // displacement
  logic signed [PosW:0] dx_q, dy_q, dz_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      dx_q <= {npx_q[PosW-1], npx_q} - {rpx_q[PosW-1], rpx_q};
      dy_q <= {npy_q[PosW-1], npy_q} - {rpy_q[PosW-1], rpy_q};
      dz_q <= {npz_q[PosW-1], npz_q} - {rpz_q[PosW-1], rpz_q};
    end
  end

  // neighbor target: real atom, mapped origin, or skipped
  logic              is_real, org_ok;
  status_e           stat_d;
  logic              upd_d;
  assign is_real = ({1'b0, idx_q} < rac_i);
  assign org_ok  = ({1'b0, norg_q} < rac_i);
  always_comb begin
    tgt_d  = idx_a;
    upd_d  = 1'b1;
    stat_d = STAT_OK;
    if (!is_real) begin
      tgt_d = AtomAw'(norg_q);
      if (!map_en_i) begin
        upd_d  = 1'b0;
        stat_d = STAT_NOMAP;
      end else if (!org_ok) begin
        upd_d  = 1'b0;
        stat_d = STAT_RANGE;
      end
    end
  end

  // shared virial multiplier
  logic signed [PosW:0]   mul_a;
  logic signed [31:0]     mul_b;
  logic signed [PosW+32:0] prod;
  logic signed [VirW-1:0] prod_q;
  always_comb begin
    unique case (cmd_i.mul_sel)
      3'd0:    begin mul_a = dx_q; mul_b = fx_q; end
      3'd1:    begin mul_a = dy_q; mul_b = fy_q; end
      3'd2:    begin mul_a = dz_q; mul_b = fz_q; end
      3'd3:    begin mul_a = dx_q; mul_b = fy_q; end
      3'd4:    begin mul_a = dx_q; mul_b = fz_q; end
      3'd5:    begin mul_a = dy_q; mul_b = fz_q; end
      default: begin mul_a = dx_q; mul_b = fx_q; end
    endcase
  end
  assign prod = mul_a * mul_b;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod[VirW-1:0];
    end
  end

  // global sums, center and status
  logic signed [VirW-1:0] vir_sel;
  assign vir_sel = (cmd_i.acc_sel < 3'd6) ? vir_q[cmd_i.acc_sel] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      etot_q   <= '0;
      for (int k = 0; k < 6; k++) vir_q[k] <= '0;
      tgt_q    <= '0;
      upd_q    <= 1'b0;
      stat_q   <= STAT_OK;
    end else begin
      if (cmd_i.clr_sums) begin
        etot_q <= '0;
        for (int k = 0; k < 6; k++) vir_q[k] <= '0;
      end
      if (cmd_i.begin_we) begin
        center_q <= idx_a;
        etot_q   <= sat48({etot_q[ForceW-1], etot_q} + {{(ForceW-31){en_q[31]}}, en_q});
      end
      if (cmd_i.acc_en && cmd_i.acc_sel < 3'd6) begin
        vir_q[cmd_i.acc_sel] <= sat64({vir_sel[VirW-1], vir_sel} + {prod_q[VirW-1], prod_q});
      end
      if (cmd_i.diff_en) begin
        tgt_q  <= tgt_d;
        upd_q  <= upd_d;
        stat_q <= stat_d;
      end
      if (cmd_i.latch) begin
        stat_q <= STAT_OK;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_o[1:0] <= (op_q == OP_PAIR) ? stat_q : STAT_OK;
      if (op_q == OP_READ) begin
        out_data_o[49:2]    <= rfx_q;
        out_data_o[97:50]   <= rfy_q;
        out_data_o[145:98]  <= rfz_q;
        out_data_o[177:146] <= ren_q;
      end else begin
        out_data_o[177:2] <= '0;
      end
      out_data_o[225:178] <= etot_q;
      out_data_o[289:226] <= vir_q[0];
      out_data_o[353:290] <= vir_q[1];
      out_data_o[417:354] <= vir_q[2];
      out_data_o[481:418] <= vir_q[3];
      out_data_o[545:482] <= vir_q[4];
      out_data_o[609:546] <= vir_q[5];
      out_data_o[615:610] <= '0;
    end
  end

  assign out_valid_o     = valid_q;
  assign stat_o.op       = op_q;
  assign stat_o.out_busy = valid_q && !out_ready_i;

endmodule

### design/pair_force_virial_accumulator.sv
// Pair force and f-dot-r virial accumulator. After reset the block sweeps its
// 4096-entry force and energy memories to zero and takes no transaction
// meanwhile (configuration writes work). Each input transaction gives one
// result: load atom, begin center, read atom and unused codes act in the
// decode step, pair force runs memory reads of neighbor, center and force
// target, then one shared 33x32 multiplier over the six virial terms, and
// clear runs a zeroing sweep. The next transaction is taken once the previous
// result is produced and the result register is free.
// depends on pfva_pkg, pfva_ctrl, pfva_dp
module pair_force_virial_accumulator
  import pfva_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // operation, atom_index, pos_x, pos_y, pos_z, origin_index,
  // force_x, force_y, force_z, center_energy
  input  logic [255:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // status, total_force_x, total_force_y, total_force_z, atom_energy_out,
  // energy_sum, virial_xx, virial_yy, virial_zz, virial_xy, virial_xz, virial_yz
  output logic [615:0] m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);

  cmd_t            cmd;
  stat_t           stat;
  logic [RacW-1:0] rac_q;
  logic            map_en_q;

  // configuration registers
  assign pready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rac_q    <= '0;
      map_en_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && pready_o) begin
      if (paddr_i[2]) begin
        map_en_q <= pwdata_i[0];
      end else begin
        rac_q <= pwdata_i[RacW-1:0];
      end
    end
  end
  assign prdata_o = paddr_i[2] ? {31'd0, map_en_q} : {{(32-RacW){1'b0}}, rac_q};

  pfva_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pfva_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .rac_i       (rac_q),
    .map_en_i    (map_en_q),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

### test/testbench.sv
// testbench for pair_force_virial_accumulator: directed and random operation
// streams checked against an in-bench model of forces, energies and virial
// depends on pfva_pkg and the accumulator RTL
`timescale 1ns / 100ps

module testbench;
  import pfva_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam logic [2:0] AddrAtomCount = 3'd0;
  localparam logic [2:0] AddrGhostMap  = 3'd4;

  typedef struct {
    logic [2:0]         op;
    logic [IdxW-1:0]    atom;
    logic signed [31:0] px, py, pz;
    logic [IdxW-1:0]    origin;
    logic signed [31:0] fx, fy, fz;
    logic signed [31:0] energy;
  } item_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [47:0] tfx, tfy, tfz;
    logic signed [31:0] aen;
    logic signed [47:0] esum;
    logic signed [63:0] vir [6];
  } result_t;

  logic         clk_i, rst_ni;
  logic [255:0] s_tdata;
  logic         s_tvalid, s_tready;
  logic [615:0] m_tdata;
  logic         m_tvalid, m_tready;
  logic         psel, penable, pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;
  logic         pready;

  pair_force_virial_accumulator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready)
  );

  // model state
  logic [12:0]        real_count;
  logic               map_on;
  logic signed [31:0] pos_x [AtomCount];
  logic signed [31:0] pos_y [AtomCount];
  logic signed [31:0] pos_z [AtomCount];
  logic [IdxW-1:0]    origin_of [AtomCount];
  logic               loaded [AtomCount];
  logic signed [47:0] frc_x [AtomCount];
  logic signed [47:0] frc_y [AtomCount];
  logic signed [47:0] frc_z [AtomCount];
  logic signed [31:0] atom_energy [AtomCount];
  logic signed [47:0] energy_acc;
  logic signed [63:0] virial [6];
  logic [IdxW-1:0]    center;
  int                 loaded_list [$];

  result_t     pending_results [$];
  int          errors;
  int          send_idle, recv_stall, hold_off;
  int unsigned cycles;

  // clock and run limit
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // saturating adds
  function automatic logic signed [47:0] clamp48(input longint s);
    if (s > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction

  function automatic logic signed [63:0] vir_add(input logic signed [63:0] a,
                                                 input logic signed [32:0] d,
                                                 input logic signed [31:0] f);
    logic signed [64:0] prod;
    logic signed [64:0] sum;
    prod = d * f;
    sum = a + $signed(prod[63:0]);
    if (sum[64] != sum[63]) return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return sum[63:0];
  endfunction

  task automatic take_away(input logic [IdxW-1:0] a, input item_t it);
    frc_x[a] = clamp48(longint'(frc_x[a]) - longint'(it.fx));
    frc_y[a] = clamp48(longint'(frc_y[a]) - longint'(it.fy));
    frc_z[a] = clamp48(longint'(frc_z[a]) - longint'(it.fz));
  endtask

  task automatic clear_sums();
    foreach (frc_x[i]) begin
      frc_x[i] = '0; frc_y[i] = '0; frc_z[i] = '0; atom_energy[i] = '0;
    end
    energy_acc = '0;
    foreach (virial[k]) virial[k] = '0;
  endtask

  // advance the accumulator model by one transaction
  task automatic accumulate(input item_t it, output result_t r);
    logic [IdxW-1:0]    n, t;
    logic signed [32:0] dx, dy, dz;
    n = it.atom;
    r.status = STAT_OK;
    r.tfx = '0; r.tfy = '0; r.tfz = '0; r.aen = '0;
    case (it.op)
      OP_CLEAR: clear_sums();
      OP_LOAD: begin
        pos_x[n] = it.px; pos_y[n] = it.py; pos_z[n] = it.pz;
        origin_of[n] = it.origin;
        if (!loaded[n]) loaded_list.push_back(n);
        loaded[n] = 1'b1;
      end
      OP_BEGIN: begin
        center = n;
        atom_energy[n] = it.energy;
        energy_acc = clamp48(longint'(energy_acc) + longint'(it.energy));
      end
      OP_PAIR: begin
        dx = 33'(pos_x[n]) - 33'(pos_x[center]);
        dy = 33'(pos_y[n]) - 33'(pos_y[center]);
        dz = 33'(pos_z[n]) - 33'(pos_z[center]);
        frc_x[center] = clamp48(longint'(frc_x[center]) + longint'(it.fx));
        frc_y[center] = clamp48(longint'(frc_y[center]) + longint'(it.fy));
        frc_z[center] = clamp48(longint'(frc_z[center]) + longint'(it.fz));
        virial[0] = vir_add(virial[0], dx, it.fx);
        virial[1] = vir_add(virial[1], dy, it.fy);
        virial[2] = vir_add(virial[2], dz, it.fz);
        virial[3] = vir_add(virial[3], dx, it.fy);
        virial[4] = vir_add(virial[4], dx, it.fz);
        virial[5] = vir_add(virial[5], dy, it.fz);
        if (13'(n) < real_count) begin
          take_away(n, it);
        end else if (map_on) begin
          t = origin_of[n];
          if (13'(t) >= real_count) r.status = STAT_RANGE;
          else take_away(t, it);
        end else begin
          r.status = STAT_NOMAP;
        end
      end
      OP_READ: begin
        r.tfx = frc_x[n]; r.tfy = frc_y[n]; r.tfz = frc_z[n]; r.aen = atom_energy[n];
      end
      default: ;
    endcase
    r.esum = energy_acc;
    foreach (virial[k]) r.vir[k] = virial[k];
  endtask

  // send one transaction and record its expected result once accepted
  task automatic send_item(input item_t it);
    result_t r;
    logic    rdy;
    s_tdata  <= {5'd0, it.energy, it.fz, it.fy, it.fx, it.origin,
                 it.pz, it.py, it.px, it.atom, it.op};
    s_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = s_tready;
      @(posedge clk_i);
    end while (!rdy);
    accumulate(it, r);
    pending_results.push_back(r);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrAtomCount) real_count = value[12:0];
    else map_on = value[0];
  endtask

  task automatic set_config(input logic [12:0] count, input logic map);
    reg_write(AddrAtomCount, 32'(count));
    reg_write(AddrGhostMap, 32'(map));
  endtask

  function automatic item_t blank(input logic [2:0] op, input logic [IdxW-1:0] atom);
    item_t it;
    it.op = op; it.atom = atom;
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.origin = 12'($urandom); it.energy = $urandom;
    it.fx = $urandom; it.fy = $urandom; it.fz = $urandom;
    return it;
  endfunction

  task automatic load(input logic [IdxW-1:0] a, input logic signed [31:0] x, y, z,
                      input logic [IdxW-1:0] org);
    item_t it;
    it = blank(OP_LOAD, a);
    it.px = x; it.py = y; it.pz = z; it.origin = org;
    send_item(it);
  endtask

  task automatic pair(input logic [IdxW-1:0] a, input logic signed [31:0] fx, fy, fz);
    item_t it;
    it = blank(OP_PAIR, a);
    it.fx = fx; it.fy = fy; it.fz = fz;
    send_item(it);
  endtask

  // extremes, ghosts with and without map, unused codes, virial saturation
  task automatic test_directed();
    item_t it;
    set_config(13'd16, 1'b1);
    load(12'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 12'd0);
    load(12'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 12'd1);
    load(12'd20, 32'h0001_0000, 32'hFFFF_0000, 32'd0, 12'd3);
    load(12'd4095, 32'd5, 32'd7, 32'd9, 12'd4095);
    it = blank(OP_BEGIN, 12'd0); it.energy = 32'h7FFF_FFFF; send_item(it);
    pair(12'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    pair(12'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    pair(12'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    pair(12'd20, 32'h0002_0000, 32'hFFFF_8000, 32'd1);
    pair(12'd4095, 32'd100, 32'd200, 32'd300);
    it = blank(OP_BEGIN, 12'd1); it.energy = 32'h8000_0000; send_item(it);
    pair(12'd0, 32'hFFFF_FFFF, 32'd1, 32'd0);
    send_item(blank(OpSpareLo, 12'd1));
    send_item(blank(3'd6, 12'd0));
    send_item(blank(OpSpareHi, 12'd4095));
    send_item(blank(OP_READ, 12'd0));
    send_item(blank(OP_READ, 12'd1));
    send_item(blank(OP_READ, 12'd3));
    drain();
    set_config(13'd16, 1'b0);
    pair(12'd20, 32'd1, 32'd2, 32'd3);
    send_item(blank(OP_READ, 12'd0));
    send_item(blank(OP_CLEAR, 12'd0));
    send_item(blank(OP_READ, 12'd0));
    drain();
  endtask

  // mostly well-formed streams: loads, centers and runs of pairs
  task automatic test_random(input int count, input logic [12:0] rac, input logic map);
    item_t it;
    int    roll;
    set_config(rac, map);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      it = blank(OP_PAIR, 12'(loaded_list[$urandom_range(loaded_list.size() - 1)]));
      if ($urandom_range(3) == 0) begin
        it.fx = $signed(it.fx) >>> 16; it.fy = $signed(it.fy) >>> 16;
      end
      if (roll < 15) begin
        it.op = OP_LOAD;
        it.atom = ($urandom_range(2) == 0) ? 12'($urandom) : 12'($urandom_range(63));
        if ($urandom_range(1)) it.origin = 12'($urandom_range(63));
      end else if (roll < 28) begin
        it.op = OP_BEGIN;
        if ($urandom_range(9) == 0) it.atom = 12'($urandom);
      end else if (roll < 42) begin
        it.op = OP_READ;
        if ($urandom_range(3) == 0) it.atom = 12'($urandom);
      end else if (roll < 44) begin
        it.op = 3'($urandom_range(OpSpareHi, OpSpareLo));
      end else if (roll < 45 && i % 4 == 0) begin
        it.op = OP_CLEAR;
      end
      if (it.op == OP_PAIR && !loaded[center]) it.op = OP_BEGIN;
      send_item(it);
    end
    drain();
  endtask

  // result stall long enough to back the block up
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 12; i++) send_item(blank(OP_READ, 12'($urandom_range(63))));
    drain();
  endtask

  // receiver ready
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checking, sampled on the falling edge before the accepting edge
  always @(negedge clk_i) begin
    result_t e;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 64'(e.status), 64'(m_tdata[1:0]));
        check_field("total_force_x", 64'($unsigned(e.tfx)), 64'(m_tdata[49:2]));
        check_field("total_force_y", 64'($unsigned(e.tfy)), 64'(m_tdata[97:50]));
        check_field("total_force_z", 64'($unsigned(e.tfz)), 64'(m_tdata[145:98]));
        check_field("atom_energy_out", 64'($unsigned(e.aen)), 64'(m_tdata[177:146]));
        check_field("energy_sum", 64'($unsigned(e.esum)), 64'(m_tdata[225:178]));
        check_field("virial_xx", e.vir[0], m_tdata[289:226]);
        check_field("virial_yy", e.vir[1], m_tdata[353:290]);
        check_field("virial_zz", e.vir[2], m_tdata[417:354]);
        check_field("virial_xy", e.vir[3], m_tdata[481:418]);
        check_field("virial_xz", e.vir[4], m_tdata[545:482]);
        check_field("virial_yz", e.vir[5], m_tdata[609:546]);
      end
    end
  end

  initial begin
    cycles = 0; errors = 0; send_idle = 0; recv_stall = 0; hold_off = 0;
    rst_ni = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    real_count = '0; map_on = 1'b0; center = '0;
    foreach (loaded[i]) begin
      loaded[i] = 1'b0; pos_x[i] = '0; pos_y[i] = '0; pos_z[i] = '0; origin_of[i] = '0;
    end
    clear_sums();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(170, 13'd40, 1'b1);
    send_idle = 53;
    test_random(170, 13'd4096, 1'b1);
    send_idle = 0; recv_stall = 53;
    test_random(170, 13'd0, 1'b0);
    send_idle = 16; recv_stall = 16;
    test_random(170, 13'd24, 1'b1);
    test_backpressure();

    drain();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
